>>> sv/spab_pkg.sv
// ----------------------------------------------------------------------------
// spab_pkg
// Shared widths, register map, config struct and microcode word types for
// the speed PID controller with accel / brake split.
// ----------------------------------------------------------------------------
package spab_pkg;

    // fixed point
    localparam int FRAC_BITS  = 16;
    localparam int PEDAL_FRAC = 15;

    // field widths
    localparam int VEL_W    = 24;
    localparam int SPEED_W  = 24;
    localparam int DRIVE_W  = 48;
    localparam int PEDAL_W  = 16;
    localparam int TGT_W    = 23;
    localparam int GAIN_W   = 48;
    localparam int STIME_W  = 17;
    localparam int SRATE_W  = 32;

    // stream payloads
    localparam int IN_TDATA_W  = 2 * VEL_W;
    localparam int OUT_TDATA_W = SPEED_W + DRIVE_W + 2 * PEDAL_W;

    // register port
    localparam int CFG_DW   = 64;
    localparam int CFG_AW   = 6;
    localparam int ADDR_LSB = 3;

    // datapath widths
    localparam int ERR_W   = TGT_W + 2;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int INC_W   = ERR_W + STIME_W - FRAC_BITS;
    localparam int DERIV_W = DIFF_W + SRATE_W - FRAC_BITS;
    localparam int OPND_W  = 48;
    localparam int CHUNK_W = OPND_W / 2;
    localparam int PROD_W  = 2 * (CHUNK_W + 1);
    localparam int ACC_W   = 98;
    localparam int SQ_W    = 2 * SPEED_W;
    localparam int REM_W   = SPEED_W + 2;
    localparam int DRV_SH  = 2 * FRAC_BITS;
    localparam int DRV_TOP_W = ACC_W - DRV_SH - DRIVE_W + 1;

    localparam int SQRT_ITERS = SQ_W / 2;
    localparam int CNT_W      = $clog2(SQRT_ITERS);

    localparam logic signed [DRIVE_W-1:0] DRV_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRV_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};
    localparam logic [FRAC_BITS:0]        ONE_Q   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [PEDAL_W-1:0]        PEDAL_ONE = PEDAL_W'(1) << PEDAL_FRAC;

    // register map
    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_KP     = 3'd1,
        REG_KI     = 3'd2,
        REG_KD     = 3'd3,
        REG_STIME  = 3'd4,
        REG_SRATE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [TGT_W-1:0]   target;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [STIME_W-1:0] stime;
        logic [SRATE_W-1:0] srate;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target: TGT_W'(910222),
        kp:     GAIN_W'(64'd21474836480000),
        ki:     GAIN_W'(64'd42949673),
        kd:     GAIN_W'(64'd2147484),
        stime:  STIME_W'(1311),
        srate:  SRATE_W'(64'd3276800)
    };

    // microcode
    localparam int UCODE_LEN = 40;
    localparam int PC_W      = $clog2(UCODE_LEN);
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_MUL,
        DP_LOAD_RAD,
        DP_SQRT,
        DP_ERR,
        DP_INTEG,
        DP_DERIV,
        DP_DRIVE,
        DP_OUT
    } t_dp_op;

    typedef enum logic [2:0] {
        A_VX,
        A_VY,
        A_ERR,
        A_DIFF,
        A_DERIV,
        A_INTEG
    } t_a_src;

    typedef enum logic [2:0] {
        B_VX,
        B_VY,
        B_STIME,
        B_SRATE,
        B_KP,
        B_KD,
        B_KI
    } t_b_src;

    typedef enum logic [2:0] {
        C_NEXT,
        C_IN,
        C_LOOP,
        C_OUT,
        C_JMP
    } t_cond;

    typedef struct packed {
        t_dp_op op;
        t_a_src a_src;
        t_b_src b_src;
        logic   a_hi;
        logic   b_hi;
        logic   acc_first;
        t_cond  cond;
        logic   loop_init;
        t_pc    jmp;
    } t_uop;

    localparam t_uop UOP_NOP = '{
        op: DP_NOP, a_src: A_VX, b_src: B_VX, a_hi: 1'b0, b_hi: 1'b0,
        acc_first: 1'b0, cond: C_NEXT, loop_init: 1'b0, jmp: '0
    };

endpackage

>>> sv/spab_cfg.sv
// ----------------------------------------------------------------------------
// spab_cfg
// Register file behind the APB-style port: target speed, gains, step time
// and step rate.
// ----------------------------------------------------------------------------
module spab_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [spab_pkg::CFG_AW-1:0]  i_paddr,
    input  logic [spab_pkg::CFG_DW-1:0]  i_pwdata,
    output logic [spab_pkg::CFG_DW-1:0]  o_prdata,
    output logic                         o_pready,
    output spab_pkg::t_cfg               o_cfg
);
    import spab_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx      = t_reg_idx'(i_paddr[CFG_AW-1:ADDR_LSB]);
    assign wr       = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr) begin
            case (idx)
                REG_TARGET: r_cfg.target <= i_pwdata[TGT_W-1:0];
                REG_KP:     r_cfg.kp     <= i_pwdata[GAIN_W-1:0];
                REG_KI:     r_cfg.ki     <= i_pwdata[GAIN_W-1:0];
                REG_KD:     r_cfg.kd     <= i_pwdata[GAIN_W-1:0];
                REG_STIME:  r_cfg.stime  <= i_pwdata[STIME_W-1:0];
                REG_SRATE:  r_cfg.srate  <= i_pwdata[SRATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TARGET: o_prdata = CFG_DW'(r_cfg.target);
            REG_KP:     o_prdata = CFG_DW'(r_cfg.kp);
            REG_KI:     o_prdata = CFG_DW'(r_cfg.ki);
            REG_KD:     o_prdata = CFG_DW'(r_cfg.kd);
            REG_STIME:  o_prdata = CFG_DW'(r_cfg.stime);
            REG_SRATE:  o_prdata = CFG_DW'(r_cfg.srate);
            default:    o_prdata = '0;
        endcase
    end

endmodule

>>> sv/spab_seq.sv
// ----------------------------------------------------------------------------
// spab_seq
// Microcode sequencer: step counter, control store and loop counter.
// ----------------------------------------------------------------------------
module spab_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_fire,
    input  logic           i_out_busy,
    output logic           o_in_ready,
    output spab_pkg::t_uop o_uop
);
    import spab_pkg::*;

    localparam t_pc PC_START = t_pc'(0);
    localparam t_pc PC_SQRT  = t_pc'(11);

    t_pc               r_pc, n_pc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_uop              uop;

    function automatic t_uop f_mul(t_a_src a, t_b_src b, logic [1:0] k, logic first);
        t_uop u;
        u           = UOP_NOP;
        u.op        = DP_MUL;
        u.a_src     = a;
        u.b_src     = b;
        u.a_hi      = k[0];
        u.b_hi      = k[1];
        u.acc_first = first;
        return u;
    endfunction

    function automatic t_uop f_op(t_dp_op op);
        t_uop u;
        u    = UOP_NOP;
        u.op = op;
        return u;
    endfunction

    function automatic t_uop f_rom(t_pc pc);
        t_uop u;
        u = UOP_NOP;
        case (pc)
            6'd0: begin
                u      = f_op(DP_LATCH);
                u.cond = C_IN;
            end
            // sum of squares
            6'd1:  u = f_mul(A_VX, B_VX, 2'd0, 1'b1);
            6'd2:  u = f_mul(A_VX, B_VX, 2'd1, 1'b0);
            6'd3:  u = f_mul(A_VX, B_VX, 2'd2, 1'b0);
            6'd4:  u = f_mul(A_VX, B_VX, 2'd3, 1'b0);
            6'd5:  u = f_mul(A_VY, B_VY, 2'd0, 1'b0);
            6'd6:  u = f_mul(A_VY, B_VY, 2'd1, 1'b0);
            6'd7:  u = f_mul(A_VY, B_VY, 2'd2, 1'b0);
            6'd8:  u = f_mul(A_VY, B_VY, 2'd3, 1'b0);
            6'd9:  u = f_op(DP_NOP);
            6'd10: begin
                u           = f_op(DP_LOAD_RAD);
                u.loop_init = 1'b1;
            end
            6'd11: begin
                u      = f_op(DP_SQRT);
                u.cond = C_LOOP;
                u.jmp  = PC_SQRT;
            end
            6'd12: u = f_op(DP_ERR);
            // integral increment
            6'd13: u = f_mul(A_ERR, B_STIME, 2'd0, 1'b1);
            6'd14: u = f_mul(A_ERR, B_STIME, 2'd1, 1'b0);
            6'd15: u = f_mul(A_ERR, B_STIME, 2'd2, 1'b0);
            6'd16: u = f_mul(A_ERR, B_STIME, 2'd3, 1'b0);
            6'd17: u = f_op(DP_NOP);
            6'd18: u = f_op(DP_INTEG);
            // derivative
            6'd19: u = f_mul(A_DIFF, B_SRATE, 2'd0, 1'b1);
            6'd20: u = f_mul(A_DIFF, B_SRATE, 2'd1, 1'b0);
            6'd21: u = f_mul(A_DIFF, B_SRATE, 2'd2, 1'b0);
            6'd22: u = f_mul(A_DIFF, B_SRATE, 2'd3, 1'b0);
            6'd23: u = f_op(DP_NOP);
            6'd24: u = f_op(DP_DERIV);
            // drive sum
            6'd25: u = f_mul(A_ERR, B_KP, 2'd0, 1'b1);
            6'd26: u = f_mul(A_ERR, B_KP, 2'd1, 1'b0);
            6'd27: u = f_mul(A_ERR, B_KP, 2'd2, 1'b0);
            6'd28: u = f_mul(A_ERR, B_KP, 2'd3, 1'b0);
            6'd29: u = f_mul(A_DERIV, B_KD, 2'd0, 1'b0);
            6'd30: u = f_mul(A_DERIV, B_KD, 2'd1, 1'b0);
            6'd31: u = f_mul(A_DERIV, B_KD, 2'd2, 1'b0);
            6'd32: u = f_mul(A_DERIV, B_KD, 2'd3, 1'b0);
            6'd33: u = f_mul(A_INTEG, B_KI, 2'd0, 1'b0);
            6'd34: u = f_mul(A_INTEG, B_KI, 2'd1, 1'b0);
            6'd35: u = f_mul(A_INTEG, B_KI, 2'd2, 1'b0);
            6'd36: u = f_mul(A_INTEG, B_KI, 2'd3, 1'b0);
            6'd37: u = f_op(DP_NOP);
            6'd38: u = f_op(DP_DRIVE);
            6'd39: begin
                u      = f_op(DP_OUT);
                u.cond = C_OUT;
                u.jmp  = PC_START;
            end
            default: begin
                u.cond = C_JMP;
                u.jmp  = PC_START;
            end
        endcase
        return u;
    endfunction

    assign uop        = f_rom(r_pc);
    assign o_uop      = uop;
    assign o_in_ready = (uop.op == DP_LATCH);

    always_comb begin
        case (uop.cond)
            C_NEXT:  n_pc = t_pc'(r_pc + 1'b1);
            C_IN:    n_pc = i_in_fire ? t_pc'(r_pc + 1'b1) : r_pc;
            C_LOOP:  n_pc = (r_cnt != '0) ? uop.jmp : t_pc'(r_pc + 1'b1);
            C_OUT:   n_pc = i_out_busy ? r_pc : uop.jmp;
            C_JMP:   n_pc = uop.jmp;
            default: n_pc = PC_START;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (uop.loop_init) begin
            n_cnt = CNT_W'(SQRT_ITERS - 1);
        end else if (uop.cond == C_LOOP && r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_START;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> sv/spab_dp.sv
// ----------------------------------------------------------------------------
// spab_dp
// Datapath: 25x25 signed multiplier with chunked accumulate, bit-pair square
// root, integral / derivative registers, drive saturation and output stage.
// ----------------------------------------------------------------------------
module spab_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spab_pkg::t_uop                 i_uop,
    input  spab_pkg::t_cfg                 i_cfg,
    input  logic                           i_in_fire,
    input  logic [spab_pkg::VEL_W-1:0]     i_vx,
    input  logic [spab_pkg::VEL_W-1:0]     i_vy,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_out_busy,
    output logic [spab_pkg::SPEED_W-1:0]   o_speed,
    output logic [spab_pkg::DRIVE_W-1:0]   o_drive,
    output logic [spab_pkg::PEDAL_W-1:0]   o_accel,
    output logic [spab_pkg::PEDAL_W-1:0]   o_brake,
    output logic                           o_sat
);
    import spab_pkg::*;

    logic signed [VEL_W-1:0]   r_vx, r_vy;

    // multiplier
    logic signed [OPND_W-1:0]  opa, opb;
    logic                      b_sgn;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [CHUNK_W:0]   a_ch, b_ch;
    logic signed [PROD_W-1:0]  prod, r_prod;
    logic                      r_pend_v, r_pend_first;
    logic [1:0]                r_pend_sh;
    logic signed [ACC_W-1:0]   pp_ext, pp_sh, r_acc, n_acc;

    // square root
    logic [SQ_W-1:0]           r_rad;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [SPEED_W-1:0]        r_root, n_root;
    logic [REM_W+1:0]          rem_sh, trial;

    // control terms
    logic signed [ERR_W-1:0]   r_err, r_prev, n_err;
    logic signed [INC_W-1:0]   inc;
    logic signed [DRIVE_W:0]   isum;
    logic signed [DRIVE_W-1:0] r_integ, n_integ;
    logic                      r_sat, n_sat;
    logic signed [DERIV_W-1:0] r_deriv;
    logic [DRV_TOP_W-1:0]      drv_top;
    logic signed [DRIVE_W-1:0] r_drive, n_drive;

    // pedals and output stage
    logic                      pos;
    logic [DRIVE_W:0]          mag;
    logic [FRAC_BITS:0]        clamp;
    logic [PEDAL_W-1:0]        pedal;
    logic                      out_load;
    logic                      r_out_valid;
    logic [SPEED_W-1:0]        r_o_speed;
    logic [DRIVE_W-1:0]        r_o_drive;
    logic [PEDAL_W-1:0]        r_o_accel, r_o_brake;
    logic                      r_o_sat;

    assign diff = DIFF_W'(r_err) - DIFF_W'(r_prev);

    always_comb begin
        case (i_uop.a_src)
            A_VX:    opa = OPND_W'(r_vx);
            A_VY:    opa = OPND_W'(r_vy);
            A_ERR:   opa = OPND_W'(r_err);
            A_DIFF:  opa = OPND_W'(diff);
            A_DERIV: opa = OPND_W'(r_deriv);
            A_INTEG: opa = OPND_W'(r_integ);
            default: opa = '0;
        endcase
    end

    always_comb begin
        b_sgn = 1'b0;
        case (i_uop.b_src)
            B_VX: begin
                opb   = OPND_W'(r_vx);
                b_sgn = 1'b1;
            end
            B_VY: begin
                opb   = OPND_W'(r_vy);
                b_sgn = 1'b1;
            end
            B_STIME: opb = OPND_W'(i_cfg.stime);
            B_SRATE: opb = OPND_W'(i_cfg.srate);
            B_KP:    opb = OPND_W'(i_cfg.kp);
            B_KD:    opb = OPND_W'(i_cfg.kd);
            B_KI:    opb = OPND_W'(i_cfg.ki);
            default: opb = '0;
        endcase
    end

    // low chunks unsigned, high chunk of A always signed, of B per source
    assign a_ch = i_uop.a_hi ? {opa[OPND_W-1], opa[OPND_W-1:CHUNK_W]}
                             : {1'b0, opa[CHUNK_W-1:0]};
    assign b_ch = i_uop.b_hi ? {b_sgn & opb[OPND_W-1], opb[OPND_W-1:CHUNK_W]}
                             : {1'b0, opb[CHUNK_W-1:0]};
    assign prod = a_ch * b_ch;

    assign pp_ext = ACC_W'(r_prod);

    always_comb begin
        case (r_pend_sh)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext <<< CHUNK_W;
            default: pp_sh = pp_ext <<< (2 * CHUNK_W);
        endcase
    end

    always_comb begin
        n_acc = r_acc;
        if (r_pend_v) begin
            n_acc = r_pend_first ? pp_sh : r_acc + pp_sh;
        end
    end

    // one result bit per step
    assign rem_sh = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_comb begin
        if (rem_sh >= trial) begin
            n_rem  = REM_W'(rem_sh - trial);
            n_root = {r_root[SPEED_W-2:0], 1'b1};
        end else begin
            n_rem  = REM_W'(rem_sh);
            n_root = {r_root[SPEED_W-2:0], 1'b0};
        end
    end

    assign n_err = $signed({2'b00, i_cfg.target}) - $signed({1'b0, r_root});

    assign inc  = r_acc[FRAC_BITS +: INC_W];
    assign isum = (DRIVE_W + 1)'(r_integ) + (DRIVE_W + 1)'(inc);

    always_comb begin
        n_sat   = 1'b0;
        n_integ = isum[DRIVE_W-1:0];
        if (isum[DRIVE_W] != isum[DRIVE_W-1]) begin
            n_sat   = 1'b1;
            n_integ = isum[DRIVE_W] ? DRV_MIN : DRV_MAX;
        end
    end

    assign drv_top = r_acc[ACC_W-1 -: DRV_TOP_W];

    always_comb begin
        if ((&drv_top) || !(|drv_top)) begin
            n_drive = r_acc[DRV_SH +: DRIVE_W];
        end else begin
            n_drive = r_acc[ACC_W-1] ? DRV_MIN : DRV_MAX;
        end
    end

    assign pos   = !r_drive[DRIVE_W-1] && (r_drive != '0);
    assign mag   = pos ? (DRIVE_W + 1)'(r_drive) : -((DRIVE_W + 1)'(r_drive));
    assign clamp = (mag > (DRIVE_W + 1)'(ONE_Q)) ? ONE_Q : mag[FRAC_BITS:0];
    assign pedal = PEDAL_W'(clamp >> (FRAC_BITS - PEDAL_FRAC));

    assign o_out_busy = r_out_valid & ~i_out_ready;
    assign out_load   = (i_uop.op == DP_OUT) && !o_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_integ     <= '0;
        end else begin
            r_pend_v <= (i_uop.op == DP_MUL);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_uop.op == DP_INTEG) begin
                r_integ <= n_integ;
            end
            if (i_uop.op == DP_DERIV) begin
                r_prev <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod       <= prod;
        r_pend_first <= i_uop.acc_first;
        r_pend_sh    <= {1'b0, i_uop.a_hi} + {1'b0, i_uop.b_hi};
        r_acc        <= n_acc;
        if (i_uop.op == DP_LATCH && i_in_fire) begin
            r_vx <= i_vx;
            r_vy <= i_vy;
        end
        if (i_uop.op == DP_LOAD_RAD) begin
            r_rad  <= r_acc[SQ_W-1:0];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_uop.op == DP_SQRT) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
        if (i_uop.op == DP_ERR) begin
            r_err <= n_err;
        end
        if (i_uop.op == DP_INTEG) begin
            r_sat <= n_sat;
        end
        if (i_uop.op == DP_DERIV) begin
            r_deriv <= r_acc[FRAC_BITS +: DERIV_W];
        end
        if (i_uop.op == DP_DRIVE) begin
            r_drive <= n_drive;
        end
        if (out_load) begin
            r_o_speed <= r_root;
            r_o_drive <= r_drive;
            r_o_accel <= pos ? pedal : '0;
            r_o_brake <= pos ? '0 : pedal;
            r_o_sat   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed     = r_o_speed;
    assign o_drive     = r_o_drive;
    assign o_accel     = r_o_accel;
    assign o_brake     = r_o_brake;
    assign o_sat       = r_o_sat;

endmodule

>>> sv/speed_pid_accel_brake.sv
// ----------------------------------------------------------------------------
// speed_pid_accel_brake
// Fixed-point speed PID controller: speed from a velocity sample, PID drive
// value, and a split into accel and brake pedal commands.
// ----------------------------------------------------------------------------
//  channel   direction  fields (lsb first)
//  s_axis    in         tdata: velocity_x[23:0], velocity_y[47:24]
//  m_axis    out        tdata: measured_speed, drive_value, accel_pedal,
//                              brake_pedal; tuser: integral_saturated
//  apb       in/out     6 registers at byte address 8*index, 64-bit data
//
//  One item in the datapath. Its run is set by the 24-step square root
//  loop plus 28 partial products through the single 25x25 multiplier.
//  s_axis_tready is high only while the sequencer waits at its first step.
//  A result waits in the output register; the next item is taken meanwhile,
//  and the sequencer stalls at its last step only if that register is full.
//  Synchronous active-low reset clears control, the integral and the
//  previous error, and loads the register defaults.
// ----------------------------------------------------------------------------
module speed_pid_accel_brake (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spab_pkg::CFG_AW-1:0]         paddr,
    input  logic [spab_pkg::CFG_DW-1:0]         pwdata,
    output logic [spab_pkg::CFG_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // velocity_x, velocity_y
    input  logic [spab_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // measured_speed, drive_value, accel_pedal, brake_pedal
    output logic [spab_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // integral_saturated
    output logic [0:0]                          m_axis_tuser
);
    import spab_pkg::*;

    t_cfg               cfg;
    t_uop               uop;
    logic               in_fire;
    logic               out_busy;
    logic [SPEED_W-1:0] speed;
    logic [DRIVE_W-1:0] drive;
    logic [PEDAL_W-1:0] accel, brake;
    logic               sat;

    assign in_fire = s_axis_tvalid & s_axis_tready;

    spab_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    spab_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_busy (out_busy),
        .o_in_ready (s_axis_tready),
        .o_uop      (uop)
    );

    spab_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .i_cfg       (cfg),
        .i_in_fire   (in_fire),
        .i_vx        (s_axis_tdata[VEL_W-1:0]),
        .i_vy        (s_axis_tdata[2*VEL_W-1:VEL_W]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_busy  (out_busy),
        .o_speed     (speed),
        .o_drive     (drive),
        .o_accel     (accel),
        .o_brake     (brake),
        .o_sat       (sat)
    );

    assign m_axis_tdata = {brake, accel, drive, speed};
    assign m_axis_tuser = sat;

endmodule

>>> sv/spab_chk.sv
// ----------------------------------------------------------------------------
// spab_chk
// Port-level checks for the speed PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module spab_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                i_s_tready,
    input logic                                i_m_tvalid,
    input logic                                i_m_tready,
    input logic [spab_pkg::OUT_TDATA_W-1:0]    i_m_tdata
);
    import spab_pkg::*;

    localparam int DRV_LSB   = SPEED_W;
    localparam int ACCEL_LSB = SPEED_W + DRIVE_W;
    localparam int BRAKE_LSB = ACCEL_LSB + PEDAL_W;

    logic [DRIVE_W-1:0] drive;
    logic [PEDAL_W-1:0] accel, brake;

    assign drive = i_m_tdata[DRV_LSB +: DRIVE_W];
    assign accel = i_m_tdata[ACCEL_LSB +: PEDAL_W];
    assign brake = i_m_tdata[BRAKE_LSB +: PEDAL_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result dropped or changed while stalled");

    a_pedal_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (accel == '0 || brake == '0)
                       && accel <= PEDAL_ONE && brake <= PEDAL_ONE)
        else $error("pedal commands overlap or exceed full scale");

    a_pedal_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (drive[DRIVE_W-1] ? accel == '0
                                         : (brake == '0 || drive == '0)))
        else $error("pedal does not follow drive sign");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second item taken while one is in flight");

endmodule

bind speed_pid_accel_brake spab_chk u_spab_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

>>> tb/sv/tb_speed_pid_accel_brake.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speed_pid_accel_brake
// Drives velocity samples into the speed PID block and checks speed, drive
// value, pedal split and integral clamp flag against a local fixed-point
// model of the controller, across several register settings and stalls.
// ----------------------------------------------------------------------------
module tb_speed_pid_accel_brake;
    import spab_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed;
        logic signed [DRIVE_W-1:0] drive;
        logic [PEDAL_W-1:0]        accel;
        logic [PEDAL_W-1:0]        brake;
        logic                      integ_sat;
    } t_pid_out;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic                    typed_in;
        t_pid_out                want;
    } t_vel_row;

    localparam logic [2:0] UNMAPPED_LO = 3'd6;
    localparam logic [2:0] UNMAPPED_HI = 3'd7;
    localparam longint     DRIVE_HI    = DRV_MAX;
    localparam longint     DRIVE_LO    = DRV_MIN;
    localparam int         N_PHASES    = 6;
    localparam int         PHASE_ITEMS = 72;
    localparam int         TAIL_CYCLES = 80;

    localparam t_pid_out AT_TARGET = '{speed: 24'd910222, drive: 48'sd0,
                                       accel: 16'd0, brake: 16'd0, integ_sat: 1'b0};

    // rows marked typed_in hold the result at the reset target speed
    localparam t_vel_row SAMPLE_TABLE [15] = '{
        '{vx:  24'sd910222,  vy:  24'sd0,       typed_in: 1'b1, want: AT_TARGET},
        '{vx: -24'sd910222,  vy:  24'sd0,       typed_in: 1'b1, want: AT_TARGET},
        '{vx:  24'sd0,       vy: -24'sd910222,  typed_in: 1'b1, want: AT_TARGET},
        '{vx:  24'sd0,       vy:  24'sd0,       typed_in: 1'b0, want: '0},
        '{vx:  24'sd6553600, vy:  24'sd6553600, typed_in: 1'b0, want: '0},
        '{vx: -24'sd6553600, vy: -24'sd6553600, typed_in: 1'b0, want: '0},
        '{vx:  24'sd6553600, vy: -24'sd6553600, typed_in: 1'b0, want: '0},
        '{vx: -24'sd6553600, vy:  24'sd6553600, typed_in: 1'b0, want: '0},
        '{vx:  24'sd1,       vy: -24'sd1,       typed_in: 1'b0, want: '0},
        '{vx: -24'sd1,       vy:  24'sd0,       typed_in: 1'b0, want: '0},
        '{vx:  24'sh3FFFFF,  vy:  24'sh2AAAAA,  typed_in: 1'b0, want: '0},
        '{vx: -24'sh2AAAAA,  vy: -24'sh155555,  typed_in: 1'b0, want: '0},
        '{vx:  24'sd643640,  vy:  24'sd643640,  typed_in: 1'b0, want: '0},
        '{vx:  24'sd910223,  vy:  24'sd0,       typed_in: 1'b0, want: '0},
        '{vx:  24'sd910221,  vy:  24'sd0,       typed_in: 1'b0, want: '0}
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [CFG_AW-1:0]      paddr         = '0;
    logic [CFG_DW-1:0]      pwdata        = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    t_cfg     ctrl_cfg;
    longint   prev_error_q16;
    longint   integral_q16;
    t_pid_out pid_out_q [$];
    int       err_count     = 0;
    bit       link_quiet    = 1'b0;
    int       hold_req      = 0;
    int       hold_served   = 0;
    int       rx_hold_left  = 0;

    speed_pid_accel_brake u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root = 0;
        longint unsigned bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // advances integral and previous error, returns the result of one sample
    function automatic t_pid_out predict_pid_step(input logic signed [VEL_W-1:0] vx,
                                                  input logic signed [VEL_W-1:0] vy);
        longint          sx, sy, err, integ, deriv, drv, mag;
        longint unsigned spd;
        t_wide           acc, scaled;
        logic [PEDAL_W-1:0] pedal;
        t_pid_out        r;
        sx  = vx;
        sy  = vy;
        spd = floor_sqrt(longint'(sx * sx + sy * sy));
        err = longint'(ctrl_cfg.target) - longint'(spd);

        r.integ_sat = 1'b0;
        integ = integral_q16 + ((err * longint'(ctrl_cfg.stime)) >>> FRAC_BITS);
        if (integ > DRIVE_HI) begin
            integ       = DRIVE_HI;
            r.integ_sat = 1'b1;
        end
        if (integ < DRIVE_LO) begin
            integ       = DRIVE_LO;
            r.integ_sat = 1'b1;
        end
        integral_q16 = integ;

        deriv = ((err - prev_error_q16) * longint'(ctrl_cfg.srate)) >>> FRAC_BITS;
        prev_error_q16 = err;

        acc = t_wide'(err)   * t_wide'({80'd0, ctrl_cfg.kp})
            + t_wide'(deriv) * t_wide'({80'd0, ctrl_cfg.kd})
            + t_wide'(integ) * t_wide'({80'd0, ctrl_cfg.ki});
        scaled = acc >>> DRV_SH;
        if (scaled > t_wide'(DRIVE_HI))
            drv = DRIVE_HI;
        else if (scaled < t_wide'(DRIVE_LO))
            drv = DRIVE_LO;
        else
            drv = longint'(scaled);

        mag = (drv > 0) ? drv : -drv;
        if (mag > longint'(ONE_Q)) mag = longint'(ONE_Q);
        pedal = (mag > 0) ? PEDAL_W'(mag >>> (FRAC_BITS - PEDAL_FRAC)) : '0;

        r.speed = spd[SPEED_W-1:0];
        r.drive = drv[DRIVE_W-1:0];
        r.accel = (drv > 0) ? pedal : '0;
        r.brake = (drv > 0) ? '0 : pedal;
        return r;
    endfunction

    function automatic int pick_gap();
        if (link_quiet) return 0;
        case ($urandom_range(0, 19))
            12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            18, 19:                 return $urandom_range(10, 90);
            default:                return 0;
        endcase
    endfunction

    // mostly samples around the set speed, with extremes and full-range noise
    function automatic logic signed [VEL_W-1:0] pick_velocity(input bit lateral);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 6553600 : -6553600;
            1: v = 0;
            2, 3, 4: v = int'($urandom_range(0, 13107200)) - 6553600;
            default: begin
                if (lateral)
                    v = int'($urandom_range(0, 131072)) - 65536;
                else
                    v = int'(ctrl_cfg.target) + int'($urandom_range(0, 400000)) - 200000;
            end
        endcase
        if (v > 6553600) v = 6553600;
        if (v < -6553600) v = -6553600;
        return VEL_W'(v);
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, {ADDR_LSB{1'b0}}});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TARGET: ctrl_cfg.target = value[TGT_W-1:0];
            REG_KP:     ctrl_cfg.kp     = value[GAIN_W-1:0];
            REG_KI:     ctrl_cfg.ki     = value[GAIN_W-1:0];
            REG_KD:     ctrl_cfg.kd     = value[GAIN_W-1:0];
            REG_STIME:  ctrl_cfg.stime  = value[STIME_W-1:0];
            REG_SRATE:  ctrl_cfg.srate  = value[SRATE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic signed [VEL_W-1:0] vx,
                               input logic signed [VEL_W-1:0] vy,
                               input logic typed_in, input t_pid_out want);
        int       gap;
        t_pid_out model;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
        model = predict_pid_step(vx, vy);
        pid_out_q.push_back(typed_in ? want : model);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pid_out_q.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // receiver: random back-pressure, long holds on request or by chance
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (hold_req != hold_served) begin
            hold_served   <= hold_served + 1;
            m_axis_tready <= 1'b0;
            rx_hold_left  <= 400;
        end else if (link_quiet) begin
            m_axis_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 999))
                0: begin
                    m_axis_tready <= 1'b0;
                    rx_hold_left  <= $urandom_range(100, 300);
                end
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
                21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37, 38,
                39, 40, 41, 42, 43, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56,
                57, 58, 59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 69, 70, 71, 72, 73, 74,
                75, 76, 77, 78, 79, 80, 81, 82, 83, 84, 85, 86, 87, 88, 89, 90, 91, 92,
                93, 94, 95, 96, 97, 98, 99, 100: begin
                    m_axis_tready <= 1'b0;
                    rx_hold_left  <= $urandom_range(0, 3);
                end
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pid_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pid_out_q.size() == 0) begin
                $error("result transaction with nothing pending");
                err_count++;
            end else begin
                want = pid_out_q.pop_front();
                if (m_axis_tdata[SPEED_W-1:0] !== want.speed) begin
                    $error("measured_speed: expected %0d, got %0d", want.speed,
                           m_axis_tdata[SPEED_W-1:0]);
                    err_count++;
                end
                if (m_axis_tdata[SPEED_W +: DRIVE_W] !== want.drive) begin
                    $error("drive_value: expected %0d, got %0d", want.drive,
                           $signed(m_axis_tdata[SPEED_W +: DRIVE_W]));
                    err_count++;
                end
                if (m_axis_tdata[SPEED_W+DRIVE_W +: PEDAL_W] !== want.accel) begin
                    $error("accel_pedal: expected %0d, got %0d", want.accel,
                           m_axis_tdata[SPEED_W+DRIVE_W +: PEDAL_W]);
                    err_count++;
                end
                if (m_axis_tdata[SPEED_W+DRIVE_W+PEDAL_W +: PEDAL_W] !== want.brake) begin
                    $error("brake_pedal: expected %0d, got %0d", want.brake,
                           m_axis_tdata[SPEED_W+DRIVE_W+PEDAL_W +: PEDAL_W]);
                    err_count++;
                end
                if (m_axis_tuser[0] !== want.integ_sat) begin
                    $error("integral_saturated: expected %0d, got %0d", want.integ_sat,
                           m_axis_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_speed_pid_accel_brake: done, errors");
        $finish;
    end

    initial begin
        t_cfg          phase_cfg;
        logic [63:0]   junk;
        ctrl_cfg       = CFG_RESET;
        prev_error_q16 = 0;
        integral_q16   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SAMPLE_TABLE[i])
            send_sample(SAMPLE_TABLE[i].vx, SAMPLE_TABLE[i].vy,
                        SAMPLE_TABLE[i].typed_in, SAMPLE_TABLE[i].want);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p)
                0: phase_cfg = '{target: TGT_W'(6553600), kp: '1, ki: '1, kd: '1,
                                 stime: STIME_W'(65536), srate: '1};
                1: phase_cfg = '{target: '0, kp: '0, ki: '0, kd: '0,
                                 stime: STIME_W'(1), srate: SRATE_W'(65536)};
                4: phase_cfg = CFG_RESET;
                default: begin
                    phase_cfg.target = TGT_W'($urandom_range(0, 6553600));
                    phase_cfg.kp     = GAIN_W'({$urandom, $urandom}) >> $urandom_range(0, 47);
                    phase_cfg.ki     = GAIN_W'({$urandom, $urandom}) >> $urandom_range(0, 47);
                    phase_cfg.kd     = GAIN_W'({$urandom, $urandom}) >> $urandom_range(0, 47);
                    phase_cfg.stime  = STIME_W'($urandom_range(1, 65536));
                    phase_cfg.srate  = SRATE_W'($urandom_range(65536, 32'hFFFF_FFFF));
                end
            endcase
            // bits above each register's width must be dropped
            junk = (p == 4) ? {$urandom, $urandom} : '0;
            apb_write(REG_TARGET, {junk[63:TGT_W], phase_cfg.target});
            apb_write(REG_KP,     {junk[63:GAIN_W], phase_cfg.kp});
            apb_write(REG_KI,     {junk[63:GAIN_W], phase_cfg.ki});
            apb_write(REG_KD,     {junk[63:GAIN_W], phase_cfg.kd});
            apb_write(REG_STIME,  {junk[63:STIME_W], phase_cfg.stime});
            apb_write(REG_SRATE,  {junk[63:SRATE_W], phase_cfg.srate});
            if (p == 2) begin
                apb_write(UNMAPPED_LO, {$urandom, $urandom});
                apb_write(UNMAPPED_HI, {$urandom, $urandom});
            end
            psel    <= 1'b0;
            penable <= 1'b0;
            link_quiet <= (p == N_PHASES - 1);
            if (p == 0) hold_req <= hold_req + 1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) wait_drained();
                send_sample(pick_velocity(1'b0), pick_velocity(1'b1), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_speed_pid_accel_brake: done, clean");
        else
            $display("tb_speed_pid_accel_brake: done, errors");
        $finish;
    end

endmodule

>>> speed_pid_accel_brake.f
sv/spab_pkg.sv
sv/spab_cfg.sv
sv/spab_seq.sv
sv/spab_dp.sv
sv/speed_pid_accel_brake.sv
sv/spab_chk.sv
tb/sv/tb_speed_pid_accel_brake.sv
